// ===== design/fqta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqta_pkg
// Shared types and constants for the Q4 temperature to ASCII text unit.
// ----------------------------------------------------------------------------
package fqta_pkg;

    localparam int READING_W   = 11;
    localparam int CHAR_W      = 6;
    localparam int FRAC_DIGITS = 4;
    localparam int MAX_CHARS   = 8;
    localparam int CNT_W       = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 6'd46;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [MAX_CHARS-1:0][CHAR_W-1:0] t_chars;

    // One formatted reading: characters in send order, entry 0 first
    typedef struct packed {
        t_chars             chars;
        logic [CNT_W-1:0]   count;
    } t_text;

    // Decimal digit to ASCII
    function automatic t_char digit_char(input logic [3:0] d);
        digit_char = CHAR_ZERO + {2'b00, d};
    endfunction

    // Four BCD fraction digits of nibble * 625, most significant in [15:12]
    function automatic logic [15:0] frac_bcd(input logic [3:0] n);
        logic [15:0] v;
        unique case (n)
            4'd0:  v = 16'h0000;
            4'd1:  v = 16'h0625;
            4'd2:  v = 16'h1250;
            4'd3:  v = 16'h1875;
            4'd4:  v = 16'h2500;
            4'd5:  v = 16'h3125;
            4'd6:  v = 16'h3750;
            4'd7:  v = 16'h4375;
            4'd8:  v = 16'h5000;
            4'd9:  v = 16'h5625;
            4'd10: v = 16'h6250;
            4'd11: v = 16'h6875;
            4'd12: v = 16'h7500;
            4'd13: v = 16'h8125;
            4'd14: v = 16'h8750;
            4'd15: v = 16'h9375;
        endcase
        frac_bcd = v;
    endfunction

endpackage

// ===== design/fqta_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqta_pipe
// Three-stage formatting pipeline: split hundreds, divide by ten, build text.
// ----------------------------------------------------------------------------
module fqta_pipe (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [fqta_pkg::READING_W-1:0]  i_reading,
    output logic                            o_valid,
    input  logic                            i_ready,
    output fqta_pkg::t_text                 o_text
);

    // Stage 1: hundreds flag, remainder below 100, fraction digits
    logic        r_v1;
    logic        r_hund;
    logic [6:0]  r_rem;
    logic [15:0] r_frac;

    // Stage 2: integer digits split, fraction digits carried along
    logic        r_v2;
    logic        r_hund2;
    logic [3:0]  r_tens;
    logic [3:0]  r_ones;
    logic [15:0] r_frac2;

    // Stage 3: finished text
    logic            r_v3;
    fqta_pkg::t_text r_text;

    logic en1, en2, en3;
    logic [6:0]  whole;
    logic        n_hund;
    logic [6:0]  n_rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic [6:0]  ones_full;
    fqta_pkg::t_text n_text;

    // Advance a stage when it is empty or its successor takes its item
    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;
    assign o_text  = r_text;

    // Split whole degrees (0..127) into hundreds flag and remainder
    assign whole  = i_reading[fqta_pkg::READING_W-1:4];
    assign n_hund = (whole >= 7'd100);
    assign n_rem  = n_hund ? (whole - 7'd100) : whole;

    // Divide remainder by ten with reciprocal multiply (exact below 100)
    assign prod      = 15'(r_rem) * 15'd205;
    assign tens      = prod[14:11];
    assign ones_full = r_rem - 7'(tens) * 7'd10;
    assign ones      = ones_full[3:0];

    // Assemble characters: integer digits, point, four fraction digits
    always_comb begin
        n_text.chars = '0;
        if (r_hund2) begin
            n_text.count    = 4'd8;
            n_text.chars[0] = fqta_pkg::digit_char(4'd1);
            n_text.chars[1] = fqta_pkg::digit_char(r_tens);
            n_text.chars[2] = fqta_pkg::digit_char(r_ones);
            n_text.chars[3] = fqta_pkg::CHAR_POINT;
            n_text.chars[4] = fqta_pkg::digit_char(r_frac2[15:12]);
            n_text.chars[5] = fqta_pkg::digit_char(r_frac2[11:8]);
            n_text.chars[6] = fqta_pkg::digit_char(r_frac2[7:4]);
            n_text.chars[7] = fqta_pkg::digit_char(r_frac2[3:0]);
        end else if (r_tens != 4'd0) begin
            n_text.count    = 4'd7;
            n_text.chars[0] = fqta_pkg::digit_char(r_tens);
            n_text.chars[1] = fqta_pkg::digit_char(r_ones);
            n_text.chars[2] = fqta_pkg::CHAR_POINT;
            n_text.chars[3] = fqta_pkg::digit_char(r_frac2[15:12]);
            n_text.chars[4] = fqta_pkg::digit_char(r_frac2[11:8]);
            n_text.chars[5] = fqta_pkg::digit_char(r_frac2[7:4]);
            n_text.chars[6] = fqta_pkg::digit_char(r_frac2[3:0]);
        end else begin
            // zero integer part still yields one '0'
            n_text.count    = 4'd6;
            n_text.chars[0] = fqta_pkg::digit_char(r_ones);
            n_text.chars[1] = fqta_pkg::CHAR_POINT;
            n_text.chars[2] = fqta_pkg::digit_char(r_frac2[15:12]);
            n_text.chars[3] = fqta_pkg::digit_char(r_frac2[11:8]);
            n_text.chars[4] = fqta_pkg::digit_char(r_frac2[7:4]);
            n_text.chars[5] = fqta_pkg::digit_char(r_frac2[3:0]);
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // Payload, held while a stage is stalled
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_hund <= n_hund;
            r_rem  <= n_rem;
            r_frac <= fqta_pkg::frac_bcd(i_reading[3:0]);
        end
        if (en2) begin
            r_hund2 <= r_hund;
            r_tens  <= tens;
            r_ones  <= ones;
            r_frac2 <= r_frac;
        end
        if (en3) r_text <= n_text;
    end

endmodule

// ===== design/fixed_q4_temp_to_ascii_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_q4_temp_to_ascii_unit
// Converts unsigned 7.4 fixed-point temperature readings to decimal ASCII.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (i_s_*) takes one reading per item in tdata[10:0]; bits
//   10..4 are whole degrees, bits 3..0 sixteenths. Upper tdata bits ignored.
//   Master channel (o_m_*) sends one character per item in tdata[5:0]:
//   integer digits without leading zeros (a single '0' below one degree),
//   '.', then four fraction digits. tlast marks the final fraction digit.
// Path: an accepted reading passes the three formatting stages and then
//   loads into the output shift register, whose entry 0 is on the bus.
// Throughput: one character per cycle while i_m_tready is high, set by the
//   output shift register, which reloads as its last character leaves.
//   Three formatting stages ahead of it take readings while text is sent.
// Reset: clears all valid bits and the character count; no item is pending
//   afterwards.
// Stall: when i_m_tready is low the current character holds, the pipeline
//   fills up and then o_s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module fixed_q4_temp_to_ascii_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [10:0] reading
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [5:0] text_char
    output logic        o_m_tlast    // last_char
);

    logic            pipe_valid;
    logic            ser_ready;
    fqta_pkg::t_text pipe_text;

    // Output shift register: entry 0 is the character on the bus
    fqta_pkg::t_chars              r_chars;
    fqta_pkg::t_chars              n_chars;
    logic [fqta_pkg::CNT_W-1:0]    r_left;
    logic [fqta_pkg::CNT_W-1:0]    n_left;
    logic                          load;

    fqta_pipe u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_reading (i_s_tdata[fqta_pkg::READING_W-1:0]),
        .o_valid   (pipe_valid),
        .i_ready   (ser_ready),
        .o_text    (pipe_text)
    );

    // Take a new text when empty or as the last character leaves
    assign ser_ready = (r_left == '0) || ((r_left == 4'd1) && i_m_tready);
    assign load      = pipe_valid && ser_ready;

    always_comb begin
        n_chars = r_chars;
        n_left  = r_left;
        if (load) begin
            n_chars = pipe_text.chars;
            n_left  = pipe_text.count;
        end else if ((r_left != '0) && i_m_tready) begin
            n_chars = {fqta_pkg::CHAR_W'(0), r_chars[fqta_pkg::MAX_CHARS-1:1]};
            n_left  = r_left - 4'd1;
        end
    end

    // Clear count under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    // Shift characters
    always_ff @(posedge i_clk) begin
        r_chars <= n_chars;
    end

    assign o_m_tvalid = (r_left != '0);
    assign o_m_tdata  = {2'b00, r_chars[0]};
    assign o_m_tlast  = (r_left == 4'd1);

endmodule
